>>> rtl/v3n_pkg.sv
// Shared constants for the vector normaliser pipeline.
package v3n_pkg;

    // Component width used from each input (sign-extended from the top bit)
    localparam int COMP_WIDTH = 32;
    // Fraction bits of the Q1.30 result
    localparam int Q_FRAC     = 30;
    // Lanes: x, y, z, w
    localparam int NUM_LANES  = 4;
    // Quotient bits resolved, one per pipeline stage
    localparam int QBITS      = 32;
    localparam int MAG_W      = COMP_WIDTH;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ACC_W      = SUM_W + 2 * QBITS + 2;
    localparam int OUT_W      = 32;

endpackage

>>> rtl/vec3_normalize_top.sv
// Vector normaliser: exact reciprocal-square-root scaling of x, y, z and w.
// Stages from input transaction to result register: magnitude, square, initial remainder, the quotient-bit stages.
// Throughput: one transaction per cycle while the output is not stalled; the 32 quotient-bit stages set the depth.
// A stall at the output holds every stage in place.
// Reset (rst_n, asynchronous, active low) clears all valid bits and w_mode.
// The quotient search is restoring: each stage fixes one bit with one wide add and compare.
module vec3_normalize_top
    import v3n_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] comp_x,
    input  logic [31:0] comp_y,
    input  logic [31:0] comp_z,
    input  logic [31:0] comp_w,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] norm_x,
    output logic [31:0] norm_y,
    output logic [31:0] norm_z,
    output logic [31:0] norm_w,
    output logic        w_written,
    output logic        w_saturated,
    output logic        zero_length,
    output logic        last_result
);

    logic en;
    logic w_mode_reg;

    // Magnitude stage
    logic                 a_valid_reg;
    logic                 a_last_reg;
    logic [MAG_W-1:0]     a_mag_reg [NUM_LANES];
    logic                 a_neg_reg [NUM_LANES];
    // Square stage
    logic                 b_valid_reg;
    logic                 b_last_reg;
    logic [SQ_W-1:0]      b_sq_reg  [NUM_LANES];
    logic                 b_neg_reg [NUM_LANES];
    // Iteration stages: index 0 is the initial state, index k after k bits
    logic                 i_valid_reg [QBITS+1];
    logic                 i_last_reg  [QBITS+1];
    logic [SUM_W-1:0]     i_s_reg     [QBITS+1];
    logic [NUM_LANES-1:0] i_neg_reg   [QBITS+1];
    logic [ACC_W-1:0]     i_r_reg     [QBITS+1][NUM_LANES];
    logic [ACC_W-1:0]     i_t_reg     [QBITS+1][NUM_LANES];
    logic [QBITS-1:0]     i_q_reg     [QBITS+1][NUM_LANES];
    // Result register
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     norm_reg [NUM_LANES];
    logic                 w_written_reg, w_saturated_reg, zero_length_reg, last_reg;

    logic [COMP_WIDTH-1:0] comp_in [NUM_LANES];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign comp_in[0] = comp_x[COMP_WIDTH-1:0];
    assign comp_in[1] = comp_y[COMP_WIDTH-1:0];
    assign comp_in[2] = comp_z[COMP_WIDTH-1:0];
    assign comp_in[3] = comp_w[COMP_WIDTH-1:0];

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_mode_reg <= 1'b0;
        else if (cfg_we)
            w_mode_reg <= cfg_data;
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= QBITS; k++)
                i_valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg    <= in_valid;
            b_valid_reg    <= a_valid_reg;
            i_valid_reg[0] <= b_valid_reg;
            for (int k = 0; k < QBITS; k++)
                i_valid_reg[k+1] <= i_valid_reg[k];
            out_valid_reg  <= i_valid_reg[QBITS];
        end
    end

    // Magnitude, square and initial remainder stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_last_reg <= last_item;
            b_last_reg <= a_last_reg;
            i_last_reg[0] <= b_last_reg;
            i_s_reg[0] <= {2'b00, b_sq_reg[0]} + {2'b00, b_sq_reg[1]}
                        + {2'b00, b_sq_reg[2]};
            for (int l = 0; l < NUM_LANES; l++)
            begin
                a_neg_reg[l] <= comp_in[l][COMP_WIDTH-1];
                a_mag_reg[l] <= comp_in[l][COMP_WIDTH-1] ? (~comp_in[l] + 1'b1)
                                                         : comp_in[l];
                b_neg_reg[l] <= a_neg_reg[l];
                b_sq_reg[l]  <= SQ_W'(a_mag_reg[l]) * SQ_W'(a_mag_reg[l]);
                i_neg_reg[0][l] <= b_neg_reg[l];
                i_r_reg[0][l] <= ACC_W'(b_sq_reg[l]) << (2 * Q_FRAC);
                i_t_reg[0][l] <= '0;
                i_q_reg[0][l] <= '0;
            end
        end
    end

    // One quotient bit per stage: try (q + 2^b)^2 * s against m^2 * 2^60
    for (genvar k = 0; k < QBITS; k++)
    begin : g_bit
        localparam int B = QBITS - 1 - k;
        logic [ACC_W-1:0] term [NUM_LANES];
        logic [ACC_W-1:0] s_ext;
        assign s_ext = ACC_W'(i_s_reg[k]);
        for (genvar l = 0; l < NUM_LANES; l++)
        begin : g_lane
            assign term[l] = (i_t_reg[k][l] << (B + 1)) + (s_ext << (2 * B));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                i_last_reg[k+1] <= i_last_reg[k];
                i_s_reg[k+1]    <= i_s_reg[k];
                i_neg_reg[k+1]  <= i_neg_reg[k];
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    if (term[l] <= i_r_reg[k][l])
                    begin
                        i_r_reg[k+1][l] <= i_r_reg[k][l] - term[l];
                        i_t_reg[k+1][l] <= i_t_reg[k][l] + (s_ext << B);
                        i_q_reg[k+1][l] <= i_q_reg[k][l] | (QBITS'(1) << B);
                    end
                    else
                    begin
                        i_r_reg[k+1][l] <= i_r_reg[k][l];
                        i_t_reg[k+1][l] <= i_t_reg[k][l];
                        i_q_reg[k+1][l] <= i_q_reg[k][l];
                    end
                end
            end
        end
    end

    // Sign, saturation and zero-length handling
    logic [QBITS-1:0] qf [NUM_LANES];
    logic [NUM_LANES-1:0] negf;
    logic             zero_f;
    logic [OUT_W-1:0] xyz_res [3];
    logic [OUT_W-1:0] w_res;
    logic             w_sat;
    logic             w_pos_sat, w_neg_sat;

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
            qf[l] = i_q_reg[QBITS][l];
        negf   = i_neg_reg[QBITS];
        zero_f = (i_s_reg[QBITS] == '0);
        for (int l = 0; l < 3; l++)
            xyz_res[l] = negf[l] ? OUT_W'(~qf[l] + 1'b1) : OUT_W'(qf[l]);
        w_pos_sat = !negf[3] && qf[3][QBITS-1];
        w_neg_sat = negf[3] && qf[3][QBITS-1] && (qf[3][QBITS-2:0] != '0);
        w_sat     = w_pos_sat || w_neg_sat;
        if (w_pos_sat)
            w_res = {1'b0, {(OUT_W-1){1'b1}}};
        else if (w_neg_sat)
            w_res = {1'b1, {(OUT_W-1){1'b0}}};
        else
            w_res = negf[3] ? OUT_W'(~qf[3] + 1'b1) : OUT_W'(qf[3]);
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg        <= i_last_reg[QBITS];
            zero_length_reg <= zero_f;
            for (int l = 0; l < 3; l++)
                norm_reg[l] <= zero_f ? '0 : xyz_res[l];
            if (zero_f || w_mode_reg)
            begin
                norm_reg[3]     <= '0;
                w_written_reg   <= 1'b0;
                w_saturated_reg <= 1'b0;
            end
            else
            begin
                norm_reg[3]     <= w_res;
                w_written_reg   <= 1'b1;
                w_saturated_reg <= w_sat;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign norm_x      = norm_reg[0];
    assign norm_y      = norm_reg[1];
    assign norm_z      = norm_reg[2];
    assign norm_w      = norm_reg[3];
    assign w_written   = w_written_reg;
    assign w_saturated = w_saturated_reg;
    assign zero_length = zero_length_reg;
    assign last_result = last_reg;

`ifndef SYNTHESIS
    // Zero-length vectors give all-zero results and no w
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> norm_x == '0 && norm_y == '0 && norm_z == '0
                                     && norm_w == '0 && !w_written)
        else $error("zero-length result not cleared");
    // Saturation only on a written w
    a_sat_written: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && w_saturated |-> w_written)
        else $error("saturation flagged on unwritten w");
    // Unwritten w reads as zero
    a_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !w_written |-> norm_w == '0)
        else $error("unwritten w not zero");
    // Pipeline advances exactly when the result slot is free or taken
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("pipeline enable mismatch");
`endif

endmodule

>>> tb/vec3_normalize_top_tb.sv
// Self-checking testbench for the vec3_normalize_top vector normaliser pipeline.
module vec3_normalize_top_tb;
    import v3n_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT_CYCLES = QBITS + 4;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_ITEMS = 1600;

    typedef struct packed {
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic [31:0] nw;
        logic        w_wr;
        logic        w_sat;
        logic        zlen;
        logic        last;
    } norm_res_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        last;
        bit          typed;
        norm_res_t   res;
    } vec_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] comp_x = '0;
    logic [31:0] comp_y = '0;
    logic [31:0] comp_z = '0;
    logic [31:0] comp_w = '0;
    logic        last_item = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [31:0] norm_w;
    logic        w_written;
    logic        w_saturated;
    logic        zero_length;
    logic        last_result;

    // Predictor state
    logic        mode_shadow = 1'b0;
    norm_res_t   norm_expected_q[$];
    bit          cur_typed = 1'b0;
    norm_res_t   cur_res;
    int unsigned n_accepted = 0;
    int unsigned err_count = 0;
    int unsigned quiet_cycles = 0;
    bit          no_idle = 1'b0;

    vec3_normalize_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .comp_x      (comp_x),
        .comp_y      (comp_y),
        .comp_z      (comp_z),
        .comp_w      (comp_w),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .norm_w      (norm_w),
        .w_written   (w_written),
        .w_saturated (w_saturated),
        .zero_length (zero_length),
        .last_result (last_result)
    );

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Magnitude and sign of a two's complement component
    function automatic logic [32:0] comp_magnitude(input logic [31:0] v, output logic neg);
        neg = v[31];
        return neg ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    endfunction

    // Largest q <= cap with q^2 * s <= mag^2 * 2^60
    function automatic logic [32:0] rsqrt_quot(input logic [32:0] mag, input logic [63:0] s,
                                               input logic [32:0] cap);
        logic [32:0]  lo;
        logic [32:0]  hi;
        logic [32:0]  mid;
        logic [131:0] lhs;
        logic [131:0] rhs;
        rhs = 132'(mag);
        rhs = (rhs * rhs) << (2 * Q_FRAC);
        lo = '0;
        hi = cap;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 33'd1) / 33'd2;
            lhs = 132'(mid);
            lhs = lhs * lhs * s;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 33'd1;
        end
        return lo;
    endfunction

    function automatic logic [31:0] signed_q(input logic [32:0] q, input logic neg);
        logic [32:0] t;
        t = neg ? (33'h0 - q) : q;
        return t[31:0];
    endfunction

    // Expected normalised vector for one transaction
    function automatic norm_res_t predict_norm(input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z, input logic [31:0] w,
                                               input logic last, input logic wm);
        norm_res_t   r;
        logic        sx, sy, sz, sw;
        logic [32:0] mx, my, mz, mw, q;
        logic [63:0] s;
        logic [32:0] unit;
        logic [32:0] lim;
        unit = 33'h1 << Q_FRAC;
        lim = 33'h1_0000_0000 >> 1;
        mx = comp_magnitude(x, sx);
        my = comp_magnitude(y, sy);
        mz = comp_magnitude(z, sz);
        mw = comp_magnitude(w, sw);
        s = 64'(mx) * 64'(mx) + 64'(my) * 64'(my) + 64'(mz) * 64'(mz);
        r = '0;
        r.last = last;
        if (s == 64'd0)
        begin
            r.zlen = 1'b1;
            return r;
        end
        r.nx = signed_q(rsqrt_quot(mx, s, unit), sx);
        r.ny = signed_q(rsqrt_quot(my, s, unit), sy);
        r.nz = signed_q(rsqrt_quot(mz, s, unit), sz);
        if (wm == 1'b0)
        begin
            q = rsqrt_quot(mw, s, lim + 33'd1);
            r.w_wr = 1'b1;
            if (!sw && q >= lim)
            begin
                r.nw = 32'h7FFF_FFFF;
                r.w_sat = 1'b1;
            end
            else if (sw && q > lim)
            begin
                r.nw = 32'h8000_0000;
                r.w_sat = 1'b1;
            end
            else
                r.nw = signed_q(q, sw);
        end
        return r;
    endfunction

    // Input transactions: record expectation; output transactions: compare
    always @(posedge clk)
    begin
        norm_res_t got;
        norm_res_t want;
        if (rst_n && in_valid && in_ready)
        begin
            if (cur_typed)
                norm_expected_q.push_back(cur_res);
            else
                norm_expected_q.push_back(predict_norm(comp_x, comp_y, comp_z, comp_w,
                                                       last_item, mode_shadow));
            n_accepted++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = '{norm_x, norm_y, norm_z, norm_w, w_written, w_saturated,
                    zero_length, last_result};
            if (norm_expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                err_count++;
            end
            else
            begin
                want = norm_expected_q.pop_front();
                if (got.nx !== want.nx)
                    $display("%0t: norm_x exp %h got %h", $realtime, want.nx, got.nx);
                if (got.ny !== want.ny)
                    $display("%0t: norm_y exp %h got %h", $realtime, want.ny, got.ny);
                if (got.nz !== want.nz)
                    $display("%0t: norm_z exp %h got %h", $realtime, want.nz, got.nz);
                if (got.nw !== want.nw)
                    $display("%0t: norm_w exp %h got %h", $realtime, want.nw, got.nw);
                if (got.w_wr !== want.w_wr)
                    $display("%0t: w_written exp %b got %b", $realtime, want.w_wr, got.w_wr);
                if (got.w_sat !== want.w_sat)
                    $display("%0t: w_saturated exp %b got %b", $realtime, want.w_sat,
                             got.w_sat);
                if (got.zlen !== want.zlen)
                    $display("%0t: zero_length exp %b got %b", $realtime, want.zlen, got.zlen);
                if (got.last !== want.last)
                    $display("%0t: last_result exp %b got %b", $realtime, want.last, got.last);
                if (got !== want)
                    err_count++;
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
        out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 37);

    // Present one vector and hold it until taken
    task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input logic [31:0] w, input logic last, input bit typed,
                            input norm_res_t res);
        int unsigned cnt;
        while (!no_idle && $urandom_range(0, 99) < 37)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        comp_x = x;
        comp_y = y;
        comp_z = z;
        comp_w = w;
        last_item = last;
        cur_typed = typed;
        cur_res = res;
        in_valid = 1'b1;
        cnt = n_accepted;
        do
            @(negedge clk);
        while (n_accepted == cnt);
    endtask

    // Let the pipeline drain before touching the mode register
    task automatic drain_pipe();
        in_valid = 1'b0;
        while (norm_expected_q.size() != 0)
            @(negedge clk);
        repeat (LAT_CYCLES + 4) @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_we = 1'b1;
        cfg_data = m;
        @(negedge clk);
        cfg_we = 1'b0;
        mode_shadow = m;
    endtask

    function automatic logic [31:0] rand_comp(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 511)) - 256);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return 32'(($urandom & 32'h0001_FFFF)) - 32'h0001_0000;
            default: return 32'h0;
        endcase
    endfunction

    vec_row_t dir_rows[$];

    initial
    begin
        vec_row_t  row;
        norm_res_t r0;
        logic [31:0] x, y, z, w;
        int kind, axis;

        // Directed rows: typed expectations where obvious (mode 0)
        r0 = '0; r0.zlen = 1'b1;
        dir_rows.push_back('{32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b1, r0});
        r0.last = 1'b1;
        dir_rows.push_back('{32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b1, 1'b1, r0});
        r0 = '0; r0.nx = 32'h4000_0000; r0.w_wr = 1'b1;
        dir_rows.push_back('{32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, r0});
        r0 = '0; r0.nx = 32'hC000_0000; r0.w_wr = 1'b1;
        dir_rows.push_back('{32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, r0});
        r0 = '0; r0.ny = 32'h4000_0000; r0.w_wr = 1'b1; r0.last = 1'b1;
        dir_rows.push_back('{32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1, r0});
        r0 = '0; r0.nz = 32'hC000_0000; r0.w_wr = 1'b1;
        dir_rows.push_back('{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, r0});
        // Saturation of w, positive and negative, and w exactly at the edge
        r0 = '0; r0.nx = 32'h4000_0000; r0.nw = 32'h7FFF_FFFF; r0.w_wr = 1'b1;
        r0.w_sat = 1'b1;
        dir_rows.push_back('{32'h1, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b1, r0});
        r0.nw = 32'h8000_0000;
        dir_rows.push_back('{32'h1, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 1'b1, r0});
        r0 = '0; r0.nx = 32'h4000_0000; r0.nw = 32'h8000_0000; r0.w_wr = 1'b1;
        dir_rows.push_back('{32'h1, 32'h0, 32'h0, 32'hFFFF_FFFE, 1'b0, 1'b1, r0});
        // Predicted rows
        dir_rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 1'b0, 1'b0, r0});
        dir_rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 1'b1, 1'b0, r0});
        dir_rows.push_back('{32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0005_0000, 1'b0, 1'b0, r0});
        dir_rows.push_back('{32'h1, 32'h1, 32'h1, 32'h2, 1'b0, 1'b0, r0});
        dir_rows.push_back('{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h5555_AAAA, 1'b1, 1'b0, r0});
        dir_rows.push_back('{32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F,
                             32'hAAAA_5555, 1'b0, 1'b0, r0});

        // Hold reset, then release it
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table under the reset mode, then in mode 1
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_vec(row.x, row.y, row.z, row.w, row.last, row.typed, row.res);
        end
        drain_pipe();
        write_mode(1'b1);
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_vec(row.x, row.y, row.z, row.w, row.last, 1'b0, r0);
        end

        // Random phases, alternating the mode; second phase runs without idling
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_pipe();
            write_mode(ph[0]);
            no_idle = (ph == 1);
            for (int n = 0; n < RAND_ITEMS / 4; n++)
            begin
                kind = $urandom_range(0, 9);
                x = rand_comp($urandom_range(0, 3));
                y = rand_comp($urandom_range(0, 3));
                z = rand_comp($urandom_range(0, 3));
                w = rand_comp($urandom_range(0, 3));
                if (kind == 0)
                begin
                    x = 0; y = 0; z = 0;
                end
                else if (kind == 1)
                begin
                    // lone axis
                    axis = $urandom_range(0, 2);
                    if (axis != 0) x = 0;
                    if (axis != 1) y = 0;
                    if (axis != 2) z = 0;
                    if (x == 0 && y == 0 && z == 0) z = $urandom | 32'h1;
                end
                else if (kind == 2)
                begin
                    // short xyz against a long w
                    x = rand_comp(1); y = rand_comp(1); z = rand_comp(1);
                    w = rand_comp($urandom_range(0, 1) ? 0 : 2);
                end
                send_vec(x, y, z, w, 1'($urandom_range(0, 1)), 1'b0, r0);
            end
            no_idle = 1'b0;
        end

        // Drain and finish
        in_valid = 1'b0;
        while (norm_expected_q.size() != 0)
            @(negedge clk);
        repeat (LAT_CYCLES + 4) @(negedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/v3n_pkg.sv
rtl/vec3_normalize_top.sv
tb/vec3_normalize_top_tb.sv
